// ----- hw/rtl/ffea_pkg.sv -----
// Shared types and constants for the first-fit extent allocator.
package ffea_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int OFF_W  = 48;
    localparam int LEN_W  = 33;
    localparam int REQ_W  = 32;
    localparam int DESC_W = 8;
    localparam int START_W = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [REQ_W-1:0]   MAX_PAYLOAD      = 32'h7FFF_FFFF;
    localparam logic [DESC_W-1:0]  DESC_RESET       = 8'd16;
    localparam logic [START_W-1:0] DATA_START_RESET = 16'd128;

    // register index (byte address / 4)
    localparam logic REG_DESC  = 1'b0;
    localparam logic REG_START = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REPORT = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_FROM_EXTENT = 3'd0,
        ST_APPENDED    = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_FREED       = 3'd3,
        ST_FULL        = 3'd4,
        ST_TOTAL       = 3'd5
    } status_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } extent_t;

    typedef struct packed {
        logic              desc_we;
        logic              start_we;
        logic [DATA_W-1:0] wdata;
    } cfg_wr_t;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    rd_first;
        logic    rd_next;
        logic    rd_prev;
        logic    rd_last;
        logic    wr_split;
        logic    wr_up;
        logic    wr_dn;
        logic    wr_front;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    append;
        logic    take_hit;
        logic    sum_clr;
        logic    sum_add;
        logic    res_load;
        status_t res_status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic too_large;
        logic count_zero;
        logic count_full;
        logic hit;
        logic exact;
        logic last;
        logic ptr_zero;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/first_fit_extent_allocator_top.sv -----
// Top level of the first-fit extent allocator: stream ports, APB registers, checks.
//
// Input stream (s_*): one transaction per request. s_tuser carries the
// command (allocate, free extent, report total), s_tdata the payload length
// and, for a free, the extent start offset. Output stream (m_*): exactly one
// result transaction per request; m_tuser carries the status code, m_tdata
// the placed offset and the total free bytes (each zero when not relevant).
// Requests are handled one at a time. The extent table has one write and
// one read port and is walked one entry per cycle, which sets the latency.
// An allocate scans the entries in order to the first extent that fits and
// appends at the end pointer if none fits; an exact fit moves the entries
// behind it up. A rejected request or an empty table skips the scan. A free
// moves every extent back one place and writes the new one at the front,
// unless the table is full. A report sums the lengths of all entries, and
// s_tready rises with the result.
// A result waits in the output register while m_tready is low; a new
// request is still accepted then, but its result waits until the register
// empties. Reset clears the extent count and loads the end pointer from the
// data_start reset value. Registers: descriptor_bytes at 0x0, data_start at
// 0x4 (also reloads the end pointer). Write them only while the block is idle.
module first_fit_extent_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ffea_pkg::ADDR_W-1:0] paddr,
    input  logic [ffea_pkg::DATA_W-1:0] pwdata,
    output logic [ffea_pkg::DATA_W-1:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [31:0] req_length, [79:32] free_offset
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [47:0] placed_offset, [95:48] total_free
    output logic [2:0]  m_tuser    // [2:0] status
);
    import ffea_pkg::*;

    dp_cmd_t            dp_cmd;
    dp_stat_t           dp_stat;
    cfg_wr_t            cfg;
    logic               in_fire;
    logic               wr_strobe;
    logic [DESC_W-1:0]  desc_bytes;
    logic [START_W-1:0] data_start;
    status_t            out_status;
    logic [OFF_W-1:0]   out_placed;
    logic [OFF_W-1:0]   out_total;

    // register decode: index is the word address
    assign pready        = 1'b1;
    assign wr_strobe     = psel && penable && pwrite && pready;
    assign cfg.desc_we   = wr_strobe && (paddr[2] == REG_DESC);
    assign cfg.start_we  = wr_strobe && (paddr[2] == REG_START);
    assign cfg.wdata     = pwdata;
    assign prdata        = (paddr[2] == REG_START) ? DATA_W'(data_start)
                                                   : DATA_W'(desc_bytes);

    assign in_fire = s_tvalid && s_tready;

    ffea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    ffea_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .cfg        (cfg),
        .desc_bytes (desc_bytes),
        .data_start (data_start),
        .in_cmd     (s_tuser),
        .in_len     (s_tdata[31:0]),
        .in_offset  (s_tdata[79:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_placed (out_placed),
        .out_total  (out_total)
    );

    assign m_tuser = out_status;
    assign m_tdata = {out_total, out_placed};

    // one request in flight: accept drops ready on the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= ST_TOTAL))
        else $error("result status code out of range");

    a_placed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_FROM_EXTENT && m_tuser != ST_APPENDED)
            |-> (m_tdata[47:0] == '0))
        else $error("placed offset nonzero for a non-allocation result");

    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_TOTAL) |-> (m_tdata[95:48] == '0))
        else $error("total nonzero for a non-report result");

endmodule

// ----- hw/rtl/ffea_datapath.sv -----
// Extent table memory, pointers, accumulators and result register.
module ffea_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ffea_pkg::dp_cmd_t         cmd,
    output ffea_pkg::dp_stat_t        stat,
    input  ffea_pkg::cfg_wr_t         cfg,
    output logic [ffea_pkg::DESC_W-1:0]  desc_bytes,
    output logic [ffea_pkg::START_W-1:0] data_start,
    input  logic [1:0]                in_cmd,
    input  logic [ffea_pkg::REQ_W-1:0]   in_len,
    input  logic [ffea_pkg::OFF_W-1:0]   in_offset,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ffea_pkg::status_t         out_status,
    output logic [ffea_pkg::OFF_W-1:0]   out_placed,
    output logic [ffea_pkg::OFF_W-1:0]   out_total
);
    import ffea_pkg::*;

    extent_t mem [TABLE_DEPTH];

    logic [DESC_W-1:0]  desc_reg;
    logic [START_W-1:0] start_reg;
    logic [OFF_W-1:0]   end_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;

    op_t                op_reg;
    logic [REQ_W-1:0]   len_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [LEN_W-1:0]   need_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;
    extent_t            rd_data_reg;
    logic [OFF_W-1:0]   placed_reg;
    logic [OFF_W-1:0]   sum_reg;
    status_t            out_status_reg;
    logic [OFF_W-1:0]   out_placed_reg;
    logic [OFF_W-1:0]   out_total_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    extent_t            mem_wd;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;
    logic [CNT_W-1:0]   ptr_plus1;

    assign ptr_plus1 = CNT_W'(ptr_reg) + CNT_W'(1);

    // write port
    always_comb
    begin
        mem_we = cmd.wr_split | cmd.wr_up | cmd.wr_dn | cmd.wr_front;
        mem_wa = '0;
        mem_wd = rd_data_reg;
        priority if (cmd.wr_split)
        begin
            mem_wa        = ptr_reg;
            mem_wd.offset = rd_data_reg.offset + OFF_W'(need_reg);
            mem_wd.length = rd_data_reg.length - need_reg;
        end
        else if (cmd.wr_up)
        begin
            mem_wa = ptr_reg - IDX_W'(1);
        end
        else if (cmd.wr_dn)
        begin
            mem_wa = ptr_reg + IDX_W'(1);
        end
        else if (cmd.wr_front)
        begin
            mem_wa        = '0;
            mem_wd.offset = off_reg;
            mem_wd.length = need_reg;
        end
        else
        begin
            mem_wa = '0;
        end
    end

    // read port; ptr tracks the address of the entry in rd_data_reg
    always_comb
    begin
        mem_re   = cmd.rd_first | cmd.rd_next | cmd.rd_prev | cmd.rd_last;
        mem_ra   = ptr_reg;
        ptr_next = ptr_reg;
        priority if (cmd.rd_first)
        begin
            mem_ra = '0;
        end
        else if (cmd.rd_next)
        begin
            mem_ra = ptr_reg + IDX_W'(1);
        end
        else if (cmd.rd_prev)
        begin
            mem_ra = ptr_reg - IDX_W'(1);
        end
        else if (cmd.rd_last)
        begin
            mem_ra = IDX_W'(count_reg - CNT_W'(1));
        end
        else
        begin
            mem_ra = ptr_reg;
        end
        if (mem_re)
        begin
            ptr_next = mem_ra;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.latch)
        begin
            op_reg   <= op_t'(in_cmd);
            len_reg  <= in_len;
            off_reg  <= in_offset;
            need_reg <= LEN_W'(in_len) + LEN_W'(desc_reg);
        end
        if (cmd.take_hit)
        begin
            placed_reg <= rd_data_reg.offset;
        end
        else if (cmd.append)
        begin
            placed_reg <= end_reg;
        end
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + OFF_W'(rd_data_reg.length);
        end
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            out_placed_reg <= (cmd.res_status == ST_FROM_EXTENT ||
                               cmd.res_status == ST_APPENDED) ? placed_reg : '0;
            out_total_reg  <= (cmd.res_status == ST_TOTAL) ? sum_reg : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg      <= DESC_RESET;
            start_reg     <= DATA_START_RESET;
            end_reg       <= OFF_W'(DATA_START_RESET);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.desc_we)
            begin
                desc_reg <= cfg.wdata[DESC_W-1:0];
            end
            if (cfg.start_we)
            begin
                start_reg <= cfg.wdata[START_W-1:0];
                end_reg   <= OFF_W'(cfg.wdata[START_W-1:0]);
            end
            else if (cmd.append)
            begin
                end_reg <= end_reg + OFF_W'(need_reg);
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.too_large  = (len_reg > MAX_PAYLOAD);
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CNT_W'(TABLE_DEPTH));
        stat.hit        = (rd_data_reg.length >= need_reg);
        stat.exact      = (rd_data_reg.length == need_reg);
        stat.last       = (ptr_plus1 >= count_reg);
        stat.ptr_zero   = (ptr_reg == '0);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign desc_bytes = desc_reg;
    assign data_start = start_reg;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_placed = out_placed_reg;
    assign out_total  = out_total_reg;

endmodule

// ----- hw/rtl/ffea_ctrl.sv -----
// Sequencer for allocate, free and report transactions.
module ffea_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  ffea_pkg::dp_stat_t stat,
    output ffea_pkg::dp_cmd_t  cmd
);
    import ffea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MOVE_UP,
        S_MOVE_DN,
        S_FRONT,
        S_SUM,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    CMD_ALLOC:
                    begin
                        priority if (stat.too_large)
                        begin
                            res_next   = ST_TOO_LARGE;
                            state_next = S_RESULT;
                        end
                        else if (stat.count_zero)
                        begin
                            cmd.append = 1'b1;
                            res_next   = ST_APPENDED;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    CMD_FREE:
                    begin
                        priority if (stat.count_full)
                        begin
                            res_next   = ST_FULL;
                            state_next = S_RESULT;
                        end
                        else if (stat.count_zero)
                        begin
                            state_next = S_FRONT;
                        end
                        else
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = S_MOVE_DN;
                        end
                    end
                    default:
                    begin
                        // report, and the unused code acts the same
                        cmd.sum_clr = 1'b1;
                        res_next    = ST_TOTAL;
                        if (stat.count_zero)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_SUM;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                priority if (stat.hit)
                begin
                    cmd.take_hit = 1'b1;
                    res_next     = ST_FROM_EXTENT;
                    if (!stat.exact)
                    begin
                        cmd.wr_split = 1'b1;
                        state_next   = S_RESULT;
                    end
                    else if (stat.last)
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_MOVE_UP;
                    end
                end
                else if (stat.last)
                begin
                    cmd.append = 1'b1;
                    res_next   = ST_APPENDED;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_MOVE_UP:
            begin
                cmd.wr_up = 1'b1;
                if (stat.last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_MOVE_DN:
            begin
                cmd.wr_dn = 1'b1;
                if (stat.ptr_zero)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                end
            end
            S_FRONT:
            begin
                cmd.wr_front = 1'b1;
                cmd.cnt_inc  = 1'b1;
                res_next     = ST_FREED;
                state_next   = S_RESULT;
            end
            S_SUM:
            begin
                cmd.sum_add = 1'b1;
                if (stat.last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ST_FROM_EXTENT;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ----- verif/ffea_tb_pkg.sv -----
// Scoreboard class for the extent allocator testbench: request predictor and result checks.
package ffea_tb_pkg;
    import ffea_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] placed;
        logic [OFF_W-1:0] total;
    } alloc_result_t;

    class extent_scoreboard;
        logic [DESC_W-1:0]  desc_bytes = DESC_RESET;
        logic [START_W-1:0] data_start = DATA_START_RESET;
        logic [OFF_W-1:0]   free_off [TABLE_DEPTH];
        logic [LEN_W-1:0]   free_len [TABLE_DEPTH];
        int unsigned        extent_cnt = 0;
        logic [OFF_W-1:0]   end_ptr = OFF_W'(DATA_START_RESET);
        alloc_result_t      expected_results [$];
        int                 errors = 0;
        int                 n_checked = 0;
        int                 status_seen [6];

        function void write_reg(input logic idx, input logic [DATA_W-1:0] val);
            if (idx == REG_DESC) begin
                desc_bytes = val[DESC_W-1:0];
            end
            else begin
                data_start = val[START_W-1:0];
                end_ptr    = OFF_W'(val[START_W-1:0]);
            end
        endfunction

        // Accepted request: update the free table copy and queue the result it yields.
        function void note_request(input logic [1:0] cmd, input logic [REQ_W-1:0] len,
                                   input logic [OFF_W-1:0] off);
            alloc_result_t    r;
            logic [LEN_W-1:0] need;
            logic [OFF_W-1:0] sum;
            bit               hit;
            int unsigned      i;
            int unsigned      j;

            r.status = ST_TOTAL;
            r.placed = '0;
            r.total  = '0;
            case (cmd)
                CMD_ALLOC:
                begin
                    if (len > MAX_PAYLOAD) begin
                        r.status = ST_TOO_LARGE;
                    end
                    else begin
                        need = LEN_W'(len) + LEN_W'(desc_bytes);
                        hit  = 1'b0;
                        for (i = 0; i < extent_cnt && !hit; i++) begin
                            if (free_len[i] >= need) begin
                                hit      = 1'b1;
                                r.status = ST_FROM_EXTENT;
                                r.placed = free_off[i];
                                if (free_len[i] == need) begin
                                    for (j = i; j + 1 < extent_cnt; j++) begin
                                        free_off[j] = free_off[j+1];
                                        free_len[j] = free_len[j+1];
                                    end
                                    extent_cnt--;
                                end
                                else begin
                                    free_off[i] = free_off[i] + OFF_W'(need);
                                    free_len[i] = free_len[i] - need;
                                end
                            end
                        end
                        if (!hit) begin
                            r.status = ST_APPENDED;
                            r.placed = end_ptr;
                            end_ptr  = end_ptr + OFF_W'(need);
                        end
                    end
                end
                CMD_FREE:
                begin
                    if (extent_cnt >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end
                    else begin
                        for (j = extent_cnt; j > 0; j--) begin
                            free_off[j] = free_off[j-1];
                            free_len[j] = free_len[j-1];
                        end
                        free_off[0] = off;
                        free_len[0] = LEN_W'(len) + LEN_W'(desc_bytes);
                        extent_cnt++;
                        r.status = ST_FREED;
                    end
                end
                default:
                begin
                    sum = '0;
                    for (i = 0; i < extent_cnt; i++)
                        sum = sum + OFF_W'(free_len[i]);
                    r.total = sum;
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(input alloc_result_t got);
            alloc_result_t want;

            if (!$isunknown(got.status) && got.status <= ST_TOTAL)
                status_seen[int'(got.status)]++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d placed %h total %h",
                         $time, got.status, got.placed, got.total);
                return;
            end
            want = expected_results.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.placed !== want.placed) begin
                errors++;
                $display("%0t: placed_offset mismatch, expected %h actual %h",
                         $time, want.placed, got.placed);
            end
            if (got.total !== want.total) begin
                errors++;
                $display("%0t: total_free mismatch, expected %h actual %h",
                         $time, want.total, got.total);
            end
        endfunction
    endclass

endpackage

// ----- verif/tb.sv -----
// Testbench top: drives requests and register writes into the extent allocator and checks results.
module tb;
    import ffea_pkg::*;
    import ffea_tb_pkg::*;

    // cmd value with no operation of its own; the block treats it as a report
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // quiet tail, well above the longest request (a walk over a full table)
    localparam int SETTLE_CYCLES     = 2 * TABLE_DEPTH + 16;
    localparam int ITEMS_PER_SEGMENT = 195;
    localparam int NUM_SEGMENTS      = 8;

    // register settings per segment, extremes included
    localparam logic [DESC_W-1:0]  DESC_PLAN  [NUM_SEGMENTS] =
        '{8'd16, 8'd255, 8'd0, 8'd1, 8'd255, 8'd0, 8'd128, 8'd37};
    localparam logic [START_W-1:0] START_PLAN [NUM_SEGMENTS] =
        '{16'd128, 16'd0, 16'd65535, 16'h8000, 16'hFFFF, 16'd0, 16'd1, 16'h1234};

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [79:0]         s_tdata  = '0;   // [31:0] req_length, [79:32] free_offset
    logic [1:0]          s_tuser  = '0;   // [1:0] cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [95:0]         m_tdata;         // [47:0] placed_offset, [95:48] total_free
    logic [2:0]          m_tuser;         // [2:0] status

    // idle/stall probabilities in percent, changed per segment
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int n_sent         = 0;

    extent_scoreboard sb = new();

    first_fit_extent_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side back-pressure: redrawn every cycle at the falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor. Both streams are sampled at the rising edge; a request and its own
    // result never complete at the same edge, so the order of the two calls is free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[31:0], s_tdata[79:32]);
            if (m_tvalid && m_tready)
                sb.check_result('{status: status_t'(m_tuser), placed: m_tdata[47:0],
                                  total: m_tdata[95:48]});
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("first_fit_extent_allocator_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver. Entered and left at a falling edge. tvalid stays high
    // after a transaction; the next call either loads new data in the same
    // step or drops tvalid for an idle stretch, never both.
    // ------------------------------------------------------------------
    task automatic send(input logic [1:0] cmd, input logic [REQ_W-1:0] len,
                        input logic [OFF_W-1:0] off);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {off, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    // Hold off the sender until every result is back, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // APB write: setup cycle, access cycle, then an idle cycle; the register
    // takes the value at the access edge. The model is updated at that same edge.
    task automatic apb_write(input logic idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read(input logic idx, input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            sb.errors++;
            $display("%0t: register %0d readback mismatch, expected %h actual %h",
                     $time, idx, want, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Only while idle. Upper pwdata bits are junk: the block keeps the field width.
    // Writing data_start also reloads the end pointer.
    task automatic set_config(input logic [DESC_W-1:0] desc, input logic [START_W-1:0] start);
        wait_drained();
        apb_write(REG_DESC, {24'($urandom()), desc});
        apb_write(REG_START, {16'($urandom()), start});
        apb_read(REG_DESC, DATA_W'(desc));
        apb_read(REG_START, DATA_W'(start));
    endtask

    // ------------------------------------------------------------------
    // Field pickers. Allocation lengths can be aimed at an extent in the
    // table so exact fits (with removal mid-table) happen often.
    // ------------------------------------------------------------------
    function automatic logic [REQ_W-1:0] pick_alloc_len(input int unsigned exact_pct);
        int unsigned      sel;
        logic [LEN_W-1:0] l;

        sel = $urandom_range(99);
        if (sel < exact_pct && sb.extent_cnt != 0)
        begin
            l = sb.free_len[$urandom_range(sb.extent_cnt - 1)];
            if (l >= LEN_W'(sb.desc_bytes) && l - LEN_W'(sb.desc_bytes) <= LEN_W'(MAX_PAYLOAD))
                return REQ_W'(l - LEN_W'(sb.desc_bytes));
            return REQ_W'($urandom_range(4096));
        end
        sel = $urandom_range(99);
        if (sel < 50)
            return REQ_W'($urandom_range(4096));
        if (sel < 60)
            return '0;
        if (sel < 70)
            return MAX_PAYLOAD - REQ_W'($urandom_range(3));
        if (sel < 80)
            return MAX_PAYLOAD + REQ_W'($urandom_range(4, 1));   // just over the limit
        return $urandom();
    endfunction

    function automatic logic [REQ_W-1:0] pick_free_len();
        int unsigned sel;

        sel = $urandom_range(99);
        if (sel < 55)
            return REQ_W'($urandom_range(8192));
        if (sel < 70)
            return '0;
        if (sel < 78)
            return '1;
        return $urandom();
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        int unsigned sel;

        sel = $urandom_range(99);
        if (sel < 10)
            return OFF_W'($urandom_range(4095));
        if (sel < 20)
            return {OFF_W{1'b1}} - OFF_W'($urandom_range(4095));   // near the top, splits wrap
        return {16'($urandom()), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus sequences
    // ------------------------------------------------------------------
    // Free until the table is full, then a few more to hit the full status.
    task automatic fill_table();
        while (sb.extent_cnt < TABLE_DEPTH)
            send(CMD_FREE, pick_free_len(), pick_offset());
        repeat ($urandom_range(3, 1))
            send(CMD_FREE, pick_free_len(), pick_offset());
    endtask

    // Mostly exact-fit allocations, emptying the table in arbitrary order.
    task automatic drain_table();
        int unsigned budget;

        budget = 40;
        while (sb.extent_cnt != 0 && budget != 0)
        begin
            send(CMD_ALLOC, pick_alloc_len(85), pick_offset());
            budget--;
        end
    endtask

    task automatic mixed_burst(input int unsigned n);
        int unsigned sel;

        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                send(CMD_ALLOC, pick_alloc_len(40), pick_offset());
            else if (sel < 83)
                send(CMD_FREE, pick_free_len(), pick_offset());
            else if (sel < 95)
                send(CMD_REPORT, $urandom(), pick_offset());
            else
                send(CMD_UNUSED, $urandom(), pick_offset());
        end
    endtask

    task automatic run_random(input int n);
        int          target;
        int unsigned kind;

        target = n_sent + n;
        while (n_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 8)
                fill_table();
            else if (kind < 25)
                drain_table();
            else if (kind < 28)
                wait_drained();          // sender holds off until all results are in
            else
                mixed_burst($urandom_range(30, 8));
        end
    endtask

    // Directed corner cases, no idling.
    task automatic directed_checks();
        // reset settings: descriptor 16, end pointer 128
        send(CMD_REPORT, '0, '0);                          // empty table sums to zero
        send(CMD_ALLOC, 32'h8000_0000, '0);                // smallest oversized request
        send(CMD_ALLOC, 32'hFFFF_FFFF, '0);                // largest oversized request
        send(CMD_ALLOC, MAX_PAYLOAD, '0);                  // largest legal, appended
        send(CMD_ALLOC, '0, '0);                           // descriptor only, appended

        // descriptor 0 so a zero-length request is truly zero-sized
        set_config(8'd0, 16'd200);
        send(CMD_ALLOC, '0, '0);                           // empty table: end pointer stays
        send(CMD_ALLOC, '0, '0);
        send(CMD_FREE, 32'd100, 48'hFFFF_FFFF_FFC0);
        send(CMD_FREE, '0, 48'h1000);                      // zero-length extent at front
        send(CMD_REPORT, '0, '0);
        send(CMD_ALLOC, '0, '0);                           // removes the zero-length extent
        send(CMD_ALLOC, 32'd90, '0);                       // split, new offset wraps past 2^48
        send(CMD_ALLOC, 32'd10, '0);                       // exact fit of the remainder
        send(CMD_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send(CMD_FREE, '0, '0);
        send(CMD_ALLOC, MAX_PAYLOAD, '0);                  // skips zero-length, splits the next
        send(CMD_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);

        // largest descriptor and start: extent lengths need all 33 bits
        set_config(8'd255, 16'hFFFF);
        send(CMD_FREE, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
        send(CMD_REPORT, 32'h5555_5555, 48'h5555_5555_5555);
        send(CMD_ALLOC, MAX_PAYLOAD, 48'hFFFF_FFFF_FFFF);
        send(CMD_ALLOC, 32'd1, '0);
        send(CMD_FREE, 32'd5, 48'h5555_5555_5555);
        send(CMD_REPORT, '0, '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, register reset values, directed part, one full
    // table, then eight random segments over four idle/stall mixes, each
    // segment with its own register setting.
    // ------------------------------------------------------------------
    initial
    begin
        int seg;

        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_read(REG_DESC, DATA_W'(DESC_RESET));
        apb_read(REG_START, DATA_W'(DATA_START_RESET));

        directed_checks();
        fill_table();

        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            set_config(DESC_PLAN[seg], START_PLAN[seg]);
            case (seg / 2)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 84;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 84;
                end
                default:
                begin
                    src_idle_pct   = 16;
                    sink_stall_pct = 16;
                end
            endcase
            run_random(ITEMS_PER_SEGMENT);
        end

        // all requests are in; wait for the last results and a quiet tail
        wait_drained();
        if (sb.expected_results.size() != 0)
        begin
            sb.errors += sb.expected_results.size();
            $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
        end

        $display("Covered %0d requests, %0d results checked, %0d register settings, ",
                 n_sent, sb.n_checked, NUM_SEGMENTS + 2);
        $display("statuses seen: extent %0d, appended %0d, too large %0d, ",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        $display("freed %0d, full %0d, total %0d",
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
        if (sb.errors == 0)
            $display("first_fit_extent_allocator_top test passed");
        else
            $display("first_fit_extent_allocator_top test failed");
        $finish;
    end

endmodule

// ----- first_fit_extent_allocator_top.f -----
hw/rtl/ffea_pkg.sv
hw/rtl/ffea_datapath.sv
hw/rtl/ffea_ctrl.sv
hw/rtl/first_fit_extent_allocator_top.sv
verif/ffea_tb_pkg.sv
verif/tb.sv
